// ===== design/gcol_pkg.sv =====
`timescale 1ns / 1ps
// Package for the greedy graph coloring block: command codes, beat types
// and shared constants. No dependencies.
package gcol_pkg;

  localparam int MaxNodesDef = 1024;
  localparam int MaxEdgesDef = 8192;
  localparam int VertexLimit = 1024;

  localparam logic [10:0] Uncolored = 11'h7FF;
  localparam logic [10:0] NoVertex  = 11'h7FF;
  localparam logic [10:0] DegreeMax = 11'd2047;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_RUN   = 2'd1,
    OP_READ  = 2'd2,
    OP_CLEAR = 2'd3
  } op_e;

  typedef struct packed {
    logic [1:0] operation;
    logic [9:0] vertex;
    logic [9:0] neighbor;
  } in_beat_t;

  typedef struct packed {
    logic [9:0]  color;
    logic        uncolored;
    logic [10:0] color_count;
    logic        load_error;
  } out_beat_t;

endpackage

// ===== design/gcol_ram.sv =====
`timescale 1ns / 1ps
// Simple dual-port synchronous RAM: one write and one registered read per cycle.
// No dependencies.
module gcol_ram #(
  parameter int Depth = 1024,
  parameter int Width = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== design/greedy_graph_coloring_top.sv =====
`timescale 1ns / 1ps
// Greedy largest-first graph coloring. Add and read handle one beat at a time;
// clear is a sweep over the vertex memories.
// Run sweeps MAX_NODES entries, then makes a pass over n vertices to find
// the top degree and one more such pass per distinct degree, reading each
// stored neighbor below n (skipping one at or above n) and probing colors.
// Reset is asynchronous; after it a sweep over MAX_NODES entries clears degrees and
// colors before the first beat is accepted. Depends on gcol_pkg and gcol_ram.
module greedy_graph_coloring_top
  import gcol_pkg::*;
#(
  parameter int MAX_NODES = MaxNodesDef,
  parameter int MAX_EDGES = MaxEdgesDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_beat_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_beat_t out_data_o,
  input  logic        cfg_we_i,
  input  logic [10:0] cfg_data_i
);

  localparam int NW   = $clog2(MAX_NODES);
  localparam int EW   = $clog2(MAX_EDGES);
  localparam int NLim = (MAX_NODES < VertexLimit) ? MAX_NODES : VertexLimit;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_ADD, S_READ, S_SCAN_RD, S_SCAN_CHK, S_NB_RD, S_NB_CHK,
    S_COL_CHK, S_ST_RD, S_ST_CHK, S_RESP
  } state_e;

  state_e      st_q;
  in_beat_t    cmd_q;
  logic [10:0] node_cnt_q;
  logic [NW-1:0] clr_q;
  logic        clr_deg_q, clr_run_q;
  logic [9:0]  vid_q, u_q, c_q;
  logic [11:0] cur_d_q;
  logic [10:0] nxt_q, rem_q, top_q, tot_q;
  logic        has_q, err_q;
  logic [EW-1:0] ptr_q;
  logic [EW:0] etot_q;
  logic [9:0]  last_q;
  logic        out_valid_q;
  out_beat_t   out_q;

  logic [NW-1:0] deg_raddr, deg_waddr, rs_raddr, rs_waddr, col_raddr, col_waddr;
  logic [NW-1:0] stp_raddr, stp_waddr;
  logic [EW-1:0] nb_raddr, nb_waddr, rs_wdata, rs_rdata;
  logic [10:0] deg_rdata, deg_wdata, col_rdata, col_wdata, stp_rdata, stp_wdata;
  logic [9:0]  nb_rdata, nb_wdata;
  logic        deg_we, rs_we, nb_we, col_we, stp_we;

  logic [10:0] n_act;
  logic        add_ok, out_free, out_load, last_v, upd, has_n, st_done;
  logic [10:0] nxt_n;

  assign n_act = (node_cnt_q > 11'(NLim)) ? 11'(NLim) : node_cnt_q;
  assign out_free = !out_valid_q || out_ready_i;
  assign out_load = ((st_q == S_READ) || (st_q == S_RESP)) && out_free;
  assign last_v = ({1'b0, vid_q} == n_act - 11'd1);

  assign add_ok = (etot_q < (EW+1)'(MAX_EDGES)) && (cmd_q.vertex >= last_q) &&
                  ({1'b0, cmd_q.vertex} < n_act) && ({1'b0, cmd_q.neighbor} < n_act) &&
                  (deg_rdata < DegreeMax);

  // Largest degree below the current level seen so far in this pass.
  assign upd   = ({1'b0, deg_rdata} < cur_d_q) && (!has_q || deg_rdata > nxt_q);
  assign has_n = (st_q == S_SCAN_CHK) ? (has_q || upd) : has_q;
  assign nxt_n = (st_q == S_SCAN_CHK && upd) ? deg_rdata : nxt_q;

  assign st_done = !((stp_rdata == {1'b0, u_q}) && ({1'b0, c_q} < n_act - 11'd1));

  always_comb begin
    deg_raddr = (st_q == S_IDLE) ? NW'(in_data_i.vertex) : NW'(vid_q);
    rs_raddr  = NW'(vid_q);
    nb_raddr  = ptr_q;
    stp_raddr = NW'(c_q);
    if (st_q == S_IDLE) begin
      col_raddr = NW'(in_data_i.vertex);
    end else if (st_q == S_READ) begin
      col_raddr = NW'(cmd_q.vertex);
    end else begin
      col_raddr = NW'(nb_rdata);
    end
    deg_we = 1'b0; deg_waddr = clr_q; deg_wdata = '0;
    rs_we  = 1'b0; rs_waddr  = NW'(cmd_q.vertex); rs_wdata = EW'(etot_q);
    nb_we  = 1'b0; nb_waddr  = EW'(etot_q); nb_wdata = cmd_q.neighbor;
    col_we = 1'b0; col_waddr = clr_q; col_wdata = Uncolored;
    stp_we = 1'b0; stp_waddr = clr_q; stp_wdata = NoVertex;
    unique case (st_q)
      S_CLR: begin
        deg_we = clr_deg_q;
        col_we = 1'b1;
        stp_we = 1'b1;
      end
      S_ADD: begin
        deg_we    = add_ok;
        deg_waddr = NW'(cmd_q.vertex);
        deg_wdata = deg_rdata + 11'd1;
        rs_we     = add_ok && (deg_rdata == 11'd0);
        nb_we     = add_ok;
      end
      S_COL_CHK: begin
        stp_we    = (col_rdata != Uncolored);
        stp_waddr = NW'(col_rdata);
        stp_wdata = {1'b0, u_q};
      end
      S_ST_CHK: begin
        col_we    = st_done;
        col_waddr = NW'(u_q);
        col_wdata = {1'b0, c_q};
      end
      default: begin
      end
    endcase
  end

  gcol_ram #(.Depth(MAX_NODES), .Width(11)) u_deg (
    .clk_i, .we_i(deg_we), .waddr_i(deg_waddr), .wdata_i(deg_wdata),
    .raddr_i(deg_raddr), .rdata_o(deg_rdata));
  gcol_ram #(.Depth(MAX_NODES), .Width(EW)) u_row (
    .clk_i, .we_i(rs_we), .waddr_i(rs_waddr), .wdata_i(rs_wdata),
    .raddr_i(rs_raddr), .rdata_o(rs_rdata));
  gcol_ram #(.Depth(MAX_EDGES), .Width(10)) u_nbr (
    .clk_i, .we_i(nb_we), .waddr_i(nb_waddr), .wdata_i(nb_wdata),
    .raddr_i(nb_raddr), .rdata_o(nb_rdata));
  gcol_ram #(.Depth(MAX_NODES), .Width(11)) u_col (
    .clk_i, .we_i(col_we), .waddr_i(col_waddr), .wdata_i(col_wdata),
    .raddr_i(col_raddr), .rdata_o(col_rdata));
  gcol_ram #(.Depth(MAX_NODES), .Width(11)) u_stp (
    .clk_i, .we_i(stp_we), .waddr_i(stp_waddr), .wdata_i(stp_wdata),
    .raddr_i(stp_raddr), .rdata_o(stp_rdata));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_CLR;
      clr_q       <= '0;
      clr_deg_q   <= 1'b1;
      clr_run_q   <= 1'b0;
      node_cnt_q  <= 11'd1024;
      etot_q      <= '0;
      last_q      <= '0;
      tot_q       <= '0;
      top_q       <= '0;
      err_q       <= 1'b0;
      has_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        node_cnt_q <= cfg_data_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (st_q)
        S_CLR: begin
          clr_q <= clr_q + NW'(1);
          if (clr_q == NW'(MAX_NODES - 1)) begin
            if (!clr_run_q) begin
              st_q <= S_IDLE;
            end else if (n_act == 11'd0) begin
              tot_q <= '0;
              st_q  <= S_RESP;
            end else begin
              cur_d_q <= 12'd2048;
              has_q   <= 1'b0;
              vid_q   <= '0;
              st_q    <= S_SCAN_RD;
            end
          end
        end
        S_IDLE: begin
          if (in_valid_i) begin
            cmd_q <= in_data_i;
            case (in_data_i.operation)
              OP_ADD:  st_q <= S_ADD;
              OP_READ: st_q <= S_READ;
              OP_RUN: begin
                clr_q     <= '0;
                clr_deg_q <= 1'b0;
                clr_run_q <= 1'b1;
                top_q     <= '0;
                st_q      <= S_CLR;
              end
              default: begin
                clr_q     <= '0;
                clr_deg_q <= 1'b1;
                clr_run_q <= 1'b0;
                etot_q    <= '0;
                last_q    <= '0;
                tot_q     <= '0;
                err_q     <= 1'b0;
                st_q      <= S_CLR;
              end
            endcase
          end
        end
        S_ADD: begin
          if (add_ok) begin
            etot_q <= etot_q + (EW+1)'(1);
            last_q <= cmd_q.vertex;
          end else begin
            err_q <= 1'b1;
          end
          st_q <= S_IDLE;
        end
        S_READ: begin
          if (out_free) begin
            out_q.color_count <= tot_q;
            out_q.load_error  <= err_q;
            if ({1'b0, cmd_q.vertex} < n_act && col_rdata != Uncolored) begin
              out_q.color     <= col_rdata[9:0];
              out_q.uncolored <= 1'b0;
            end else begin
              out_q.color     <= '0;
              out_q.uncolored <= 1'b1;
            end
            st_q <= S_IDLE;
          end
        end
        S_SCAN_RD: st_q <= S_SCAN_CHK;
        S_SCAN_CHK: begin
          if ({1'b0, deg_rdata} == cur_d_q) begin
            u_q   <= vid_q;
            ptr_q <= rs_rdata;
            rem_q <= deg_rdata;
            c_q   <= '0;
            st_q  <= (deg_rdata == 11'd0) ? S_ST_RD : S_NB_RD;
          end else begin
            has_q <= has_n;
            nxt_q <= nxt_n;
            if (!last_v) begin
              vid_q <= vid_q + 10'd1;
              st_q  <= S_SCAN_RD;
            end else if (has_n) begin
              cur_d_q <= {1'b0, nxt_n};
              has_q   <= 1'b0;
              vid_q   <= '0;
              st_q    <= S_SCAN_RD;
            end else begin
              tot_q <= top_q;
              st_q  <= S_RESP;
            end
          end
        end
        S_NB_RD: st_q <= S_NB_CHK;
        S_NB_CHK, S_COL_CHK: begin
          if (st_q == S_NB_CHK && {1'b0, nb_rdata} < n_act) begin
            st_q <= S_COL_CHK;
          end else begin
            ptr_q <= ptr_q + EW'(1);
            rem_q <= rem_q - 11'd1;
            st_q  <= (rem_q == 11'd1) ? S_ST_RD : S_NB_RD;
          end
        end
        S_ST_RD: st_q <= S_ST_CHK;
        S_ST_CHK: begin
          if (!st_done) begin
            c_q  <= c_q + 10'd1;
            st_q <= S_ST_RD;
          end else begin
            if ({1'b0, c_q} + 11'd1 > top_q) begin
              top_q <= {1'b0, c_q} + 11'd1;
            end
            if (!last_v) begin
              vid_q <= vid_q + 10'd1;
              st_q  <= S_SCAN_RD;
            end else if (has_q) begin
              cur_d_q <= {1'b0, nxt_q};
              has_q   <= 1'b0;
              vid_q   <= '0;
              st_q    <= S_SCAN_RD;
            end else begin
              tot_q <= ({1'b0, c_q} + 11'd1 > top_q) ? {1'b0, c_q} + 11'd1 : top_q;
              st_q  <= S_RESP;
            end
          end
        end
        S_RESP: begin
          if (out_free) begin
            out_q.color       <= '0;
            out_q.uncolored   <= 1'b0;
            out_q.color_count <= tot_q;
            out_q.load_error  <= err_q;
            st_q <= S_IDLE;
          end
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o  = (st_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // The edge store count never passes its capacity.
  a_etot_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    etot_q <= (EW+1)'(MAX_EDGES)) else $error("edge count overflow");

  // A run always starts with the vertex memory sweep.
  a_run_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && in_data_i.operation == OP_RUN) |=>
    (st_q == S_CLR && clr_q == '0)) else $error("run did not start sweep");

  // The color probe stays below the vertex count.
  a_probe_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_ST_CHK) |-> ({1'b0, c_q} < n_act)) else $error("color probe out of range");

  // A run result never reports more colors than vertices.
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_RESP) |-> (tot_q <= n_act)) else $error("color count out of range");

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// Testbench for greedy_graph_coloring_top: directed table, then random graphs
// checked against a behavioral coloring predictor. Depends on gcol_pkg.
module tb;
  import gcol_pkg::*;

  localparam int CycleLimit = 4000000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  in_beat_t    in_data_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  out_beat_t   out_data_o;
  logic        cfg_we_i = 1'b0;
  logic [10:0] cfg_data_i = 11'd0;

  greedy_graph_coloring_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Shadow copy of the block's graph and coloring state.
  int unsigned nbr_mem [MaxEdgesDef];
  int unsigned row_base [MaxNodesDef];
  int unsigned deg_cnt [MaxNodesDef];
  int unsigned vcolor [MaxNodesDef];
  int unsigned stamp [MaxNodesDef];
  int unsigned order [MaxNodesDef];
  int unsigned edge_total, last_vtx, num_colors, load_err, node_cfg;

  out_beat_t expected_q[$];
  int        fail_cnt = 0;
  int        results_seen = 0;
  int        beats_sent = 0;
  int        runs_sent = 0;
  int        cycles = 0;
  int        burst_left = 0;

  function automatic int unsigned nodes_used();
    return (node_cfg > VertexLimit) ? VertexLimit : node_cfg;
  endfunction

  function automatic void clear_graph();
    for (int i = 0; i < MaxNodesDef; i++) begin
      deg_cnt[i] = 0;
      vcolor[i]  = Uncolored;
      stamp[i]   = NoVertex;
    end
    edge_total = 0;
    last_vtx   = 0;
    num_colors = 0;
    load_err   = 0;
  endfunction

  function automatic void color_graph();
    int unsigned n, u, w, c, top, cur, j;
    n = nodes_used();
    top = 0;
    for (int i = 0; i < MaxNodesDef; i++) begin
      vcolor[i] = Uncolored;
      stamp[i]  = NoVertex;
    end
    // Stable insertion sort by descending degree.
    for (int unsigned i = 0; i < n; i++) begin
      cur = i;
      j = i;
      while (j > 0 && deg_cnt[order[j-1]] < deg_cnt[cur]) begin
        order[j] = order[j-1];
        j--;
      end
      order[j] = cur;
    end
    for (int unsigned k = 0; k < n; k++) begin
      u = order[k];
      for (int unsigned e = row_base[u]; deg_cnt[u] != 0 && e < row_base[u] + deg_cnt[u]
           && e < MaxEdgesDef; e++) begin
        w = nbr_mem[e];
        if (w < n && vcolor[w] != Uncolored) stamp[vcolor[w]] = u;
      end
      c = 0;
      while (c < n && stamp[c] == u) c++;
      if (c >= n) c = n - 1;
      vcolor[u] = c;
      if (c + 1 > top) top = c + 1;
    end
    num_colors = top & 11'h7FF;
  endfunction

  // Updates the shadow state for one accepted beat; returns 1 if it yields a result.
  function automatic bit predict_beat(in_beat_t b, output out_beat_t r);
    int unsigned n, v, w;
    n = nodes_used();
    v = b.vertex;
    w = b.neighbor;
    r = '0;
    case (op_e'(b.operation))
      OP_ADD: begin
        if (edge_total >= MaxEdgesDef || v < last_vtx || v >= n || w >= n ||
            deg_cnt[v] >= DegreeMax) begin
          load_err = 1;
        end else begin
          if (deg_cnt[v] == 0) row_base[v] = edge_total;
          nbr_mem[edge_total] = w;
          deg_cnt[v]++;
          edge_total++;
          last_vtx = v;
        end
        return 1'b0;
      end
      OP_CLEAR: begin
        clear_graph();
        return 1'b0;
      end
      OP_RUN: color_graph();
      default: begin
        if (v < n && vcolor[v] != Uncolored) r.color = vcolor[v][9:0];
        else r.uncolored = 1'b1;
      end
    endcase
    r.color_count = num_colors[10:0];
    r.load_error  = load_err[0];
    return 1'b1;
  endfunction

  // Drives one beat with burst/gap pacing and records its expected result.
  task automatic send_beat(in_beat_t b, bit typed = 1'b0, out_beat_t typed_res = '0);
    out_beat_t r;
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_data_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    beats_sent++;
    if (predict_beat(b, r)) begin
      if (op_e'(b.operation) == OP_RUN) runs_sent++;
      expected_q.push_back(typed ? typed_res : r);
    end
  endtask

  task automatic put(op_e op, int v = 0, int w = 0);
    in_beat_t b;
    b.operation = op;
    b.vertex    = v[9:0];
    b.neighbor  = w[9:0];
    send_beat(b);
  endtask

  // Waits until the block is idle, then writes node_count.
  task automatic set_node_count(int unsigned value);
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= value[10:0];
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    node_cfg = value;
  endtask

  // One well-formed graph load with some broken entries, a run and reads.
  task automatic graph_round(int unsigned span);
    int unsigned n, v, lim;
    n = nodes_used();
    put(OP_CLEAR);
    lim = (span == 0) ? 1 : span;
    v = $urandom_range(0, lim - 1);
    repeat ($urandom_range(0, 40)) begin
      if (v < lim && $urandom_range(0, 2) == 0) v += $urandom_range(1, 3);
      case ($urandom_range(0, 19))
        0: put(OP_ADD, $urandom_range(0, 1023), $urandom_range(0, 1023));
        1: put(OP_ADD, v, $urandom_range(0, 1023));
        2: put(OP_READ, $urandom_range(0, 1023));
        default: put(OP_ADD, v, $urandom_range(0, lim - 1));
      endcase
    end
    put(OP_RUN);
    repeat ($urandom_range(2, 8)) begin
      if ($urandom_range(0, 4) == 0) put(OP_READ, $urandom_range(0, 1023));
      else put(OP_READ, $urandom_range(0, lim - 1));
    end
  endtask

  typedef struct {
    op_e       op;
    int        v;
    int        w;
    bit        typed;
    out_beat_t res;
  } row_t;

  row_t table_q[$];

  task automatic row(op_e op, int v, int w, bit typed = 0, out_beat_t res = '0);
    row_t t;
    t.op = op; t.v = v; t.w = w; t.typed = typed; t.res = res;
    table_q.push_back(t);
  endtask

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // The receiver switches between stall patterns now and then.
  int ready_mode = 0;
  always @(posedge clk_i) begin
    if ($urandom_range(0, 99) == 0) ready_mode <= $urandom_range(0, 2);
    case (ready_mode)
      0: out_ready_i <= 1'b1;
      1: out_ready_i <= $urandom_range(0, 1);
      default: out_ready_i <= ($urandom_range(0, 4) == 0);
    endcase
  end

  always @(posedge clk_i) begin
    out_beat_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        $error("result beat with nothing expected");
        fail_cnt++;
      end else begin
        e = expected_q.pop_front();
        if (out_data_o.color !== e.color) begin
          $error("color: expected %0d, got %0d", e.color, out_data_o.color);
          fail_cnt++;
        end
        if (out_data_o.uncolored !== e.uncolored) begin
          $error("uncolored: expected %0d, got %0d", e.uncolored, out_data_o.uncolored);
          fail_cnt++;
        end
        if (out_data_o.color_count !== e.color_count) begin
          $error("color_count: expected %0d, got %0d", e.color_count,
                 out_data_o.color_count);
          fail_cnt++;
        end
        if (out_data_o.load_error !== e.load_error) begin
          $error("load_error: expected %0d, got %0d", e.load_error, out_data_o.load_error);
          fail_cnt++;
        end
      end
    end
  end

  initial begin
    in_beat_t b;
    int unsigned phase_cfg [$] = '{16, 1024, 3, 64, 2047, 1, 0, 200, 2, 1024};
    int unsigned span;
    int stop_at;
    node_cfg = 1024;
    clear_graph();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part, graph size at its reset value.
    row(OP_READ, 0, 0, 1, '{color: 0, uncolored: 1, color_count: 0, load_error: 0});
    row(OP_RUN, 0, 0, 1, '{color: 0, uncolored: 0, color_count: 1, load_error: 0});
    row(OP_READ, 1023, 0, 1, '{color: 0, uncolored: 0, color_count: 1, load_error: 0});
    row(OP_ADD, 0, 1, 0);
    row(OP_ADD, 0, 1023, 0);
    row(OP_ADD, 1, 0, 0);
    row(OP_ADD, 1023, 0, 0);
    row(OP_ADD, 5, 0, 0);
    row(OP_READ, 0, 0, 1, '{color: 0, uncolored: 0, color_count: 1, load_error: 1});
    row(OP_RUN, 0, 0);
    row(OP_READ, 0, 0);
    row(OP_READ, 1, 0);
    row(OP_READ, 1023, 0);
    row(OP_CLEAR, 0, 0);
    row(OP_READ, 0, 0, 1, '{color: 0, uncolored: 1, color_count: 0, load_error: 0});
    row(OP_ADD, 3, 3, 0);
    row(OP_ADD, 4, 3, 0);
    row(OP_RUN, 0, 0);
    row(OP_READ, 3, 0);
    row(OP_READ, 4, 0);
    foreach (table_q[i]) begin
      b.operation = table_q[i].op;
      b.vertex    = table_q[i].v[9:0];
      b.neighbor  = table_q[i].w[9:0];
      send_beat(b, table_q[i].typed, table_q[i].res);
    end

    // Random graphs over a range of graph sizes.
    foreach (phase_cfg[p]) begin
      set_node_count(phase_cfg[p]);
      stop_at = beats_sent + 100;
      while (beats_sent < stop_at) begin
        span = nodes_used();
        if (span > 64 && $urandom_range(0, 3) != 0) span = $urandom_range(2, 64);
        graph_round(span);
      end
    end

    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    $display("Sent %0d beats including %0d coloring runs; checked %0d result beats.",
             beats_sent, runs_sent, results_seen);
    $display("Graph sizes covered include 0, 1, 2 and the full 1024 vertices.");
    if (fail_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== greedy_graph_coloring_top.f =====
design/gcol_pkg.sv
design/gcol_ram.sv
design/greedy_graph_coloring_top.sv
dv/tb.sv
